// ===== rtl/uesc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uesc_pkg
// Shared types, constants and character helpers for the backslash-u decoder.
// ----------------------------------------------------------------------------
package uesc_pkg;

  localparam int ESC_LEN  = 6;   // backslash, 'u', four hex digits
  localparam int LEN_W    = 3;   // holds 0..ESC_LEN
  localparam int CP_W     = 16;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_U      = 8'h75;

  // APB byte addresses
  localparam logic [ADDR_W-1:0] ADDR_SKIP_INVALID = 3'd0;

  // UTF-8 byte count codes
  localparam logic [1:0] ENC_LEN1 = 2'd1;
  localparam logic [1:0] ENC_LEN2 = 2'd2;
  localparam logic [1:0] ENC_LEN3 = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ENC,
    ST_FLUSH
  } uesc_state_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) ||
             (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    begin
      if (c <= 8'h39) begin
        v = c - 8'h30;
      end else if (c <= 8'h46) begin
        v = c - 8'h37;
      end else begin
        v = c - 8'h57;
      end
      hex_val = v[3:0];
    end
  endfunction

  // Does byte c fit at position pos of an escape?
  function automatic logic fits_at(input logic [7:0] c, input int pos);
    if (pos == 0) begin
      fits_at = (c == CHAR_BSLASH);
    end else if (pos == 1) begin
      fits_at = (c == CHAR_U);
    end else begin
      fits_at = is_hex(c);
    end
  endfunction

endpackage

// ===== rtl/unicode_escape_to_utf8.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unicode_escape_to_utf8
// Streaming decoder of backslash-u escapes into shortest-form UTF-8.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Payload
//  -------  ---------  ------------------------  ----------------------------------
//  in       input      in_valid / in_stall       in_byte, in_end_of_string
//  out      output     out_valid / out_stall     out_byte, out_end_of_run,
//                                                out_string_done
//  cfg      input      APB psel/penable/pready   skip_invalid at byte address 0
//
// A byte is taken in ST_IDLE, then the scanner runs; the input stalls until the
// byte is done. A byte that extends a held escape prefix goes from ST_SCAN back
// to ST_IDLE. A completed escape is encoded in ST_ENC, one UTF-8 byte at a time
// (1..3 bytes). On a failure, skip mode copies out and drops the first held byte
// and rescans the rest; stop mode flushes every held byte in ST_FLUSH, then
// passes the rest of the string through ST_FLUSH. Each emitted byte waits for
// the single output register, so out_stall holds the decoder. Reset (rst_n
// low, synchronous) clears control state and sets skip_invalid to 1.
//
module unicode_escape_to_utf8 (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_byte,
  input  logic                           in_end_of_string,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_end_of_run,
  output logic                           out_string_done,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [uesc_pkg::ADDR_W-1:0]    paddr,
  input  logic [uesc_pkg::DATA_W-1:0]    pwdata,
  output logic [uesc_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  import uesc_pkg::*;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  uesc_state_t           state_r, state_nxt;
  logic [7:0]            buf_r [ESC_LEN];      // held bytes plus the new one
  logic [7:0]            buf_nxt [ESC_LEN];
  logic [LEN_W-1:0]      n_r, n_nxt;           // bytes in buf_r
  logic                  eos_r, eos_nxt;
  logic                  pass_r, pass_nxt;     // copy rest of string verbatim
  logic                  skip_r;
  logic [CP_W-1:0]       cp_r, cp_nxt;
  logic [1:0]            len_r, len_nxt;
  logic [1:0]            idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_byte_r, out_byte_nxt;
  logic                  out_eor_r, out_eor_nxt;
  logic                  out_done_r, out_done_nxt;

  // --------------------------------------------------------------------------
  // Scan logic: per-position fit checks over the buffer, and over the buffer
  // shifted by one to look ahead at the next skip-mode iteration.
  // --------------------------------------------------------------------------
  logic [ESC_LEN-1:0]    fit_vec, in_rng;
  logic [ESC_LEN-2:0]    fit_sh, in_rng_sh;
  logic                  all_fit, all_fit_sh, full_esc;
  logic [CP_W-1:0]       cp_calc;
  logic                  accept, slot_free, emit_go;
  logic                  cfg_wr;
  logic [7:0]            enc_byte;

  always_comb begin
    for (int i = 0; i < ESC_LEN; i++) begin
      fit_vec[i] = fits_at(buf_r[i], i);
      in_rng[i]  = (LEN_W'(i) < n_r);
    end
    for (int i = 0; i < ESC_LEN - 1; i++) begin
      fit_sh[i]    = fits_at(buf_r[i+1], i);
      in_rng_sh[i] = (LEN_W'(i + 1) < n_r);
    end
  end

  assign all_fit    = &(fit_vec | ~in_rng);
  assign all_fit_sh = &(fit_sh | ~in_rng_sh);
  assign full_esc   = all_fit && (n_r == LEN_W'(ESC_LEN));
  assign cp_calc    = {hex_val(buf_r[2]), hex_val(buf_r[3]),
                       hex_val(buf_r[4]), hex_val(buf_r[5])};

  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign cfg_wr    = psel && penable && pwrite && pready;

  // Pick the UTF-8 byte for the current encode step.
  always_comb begin
    case (len_r)
      ENC_LEN1: enc_byte = cp_r[7:0];
      ENC_LEN2: enc_byte = (idx_r == 2'd0) ? {3'b110, cp_r[10:6]} : {2'b10, cp_r[5:0]};
      ENC_LEN3: begin
        case (idx_r)
          2'd0:    enc_byte = {4'b1110, cp_r[15:12]};
          2'd1:    enc_byte = {2'b10, cp_r[11:6]};
          default: enc_byte = {2'b10, cp_r[5:0]};
        endcase
      end
      default: enc_byte = cp_r[7:0];
    endcase
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = pass_r ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (full_esc) begin
          state_nxt = ST_ENC;
        end else if (all_fit && !eos_r) begin
          state_nxt = ST_IDLE;
        end else if (skip_r) begin
          if (slot_free && n_r == LEN_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_ENC: begin
        if (slot_free && idx_r == len_r - 2'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (slot_free && n_r == LEN_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < ESC_LEN; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    n_nxt         = n_r;
    eos_nxt       = eos_r;
    pass_nxt      = pass_r;
    cp_nxt        = cp_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    emit_go       = 1'b0;
    out_byte_nxt  = out_byte_r;
    out_eor_nxt   = out_eor_r;
    out_done_nxt  = out_done_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // append the new byte behind the held prefix
          for (int i = 0; i < ESC_LEN; i++) begin
            if (LEN_W'(i) == n_r) begin
              buf_nxt[i] = in_byte;
            end
          end
          n_nxt   = n_r + LEN_W'(1);
          eos_nxt = in_end_of_string;
        end
      end
      ST_SCAN: begin
        if (full_esc) begin
          cp_nxt  = cp_calc;
          idx_nxt = 2'd0;
          if (cp_calc < CP_W'(16'h0080)) begin
            len_nxt = ENC_LEN1;
          end else if (cp_calc < CP_W'(16'h0800)) begin
            len_nxt = ENC_LEN2;
          end else begin
            len_nxt = ENC_LEN3;
          end
        end else if (all_fit && !eos_r) begin
          // hold the prefix for the next byte
          n_nxt = n_r;
        end else if (skip_r) begin
          if (slot_free) begin
            // copy the first byte, drop it and rescan the rest
            emit_go      = 1'b1;
            out_byte_nxt = buf_r[0];
            out_eor_nxt  = (n_r == LEN_W'(1)) || (all_fit_sh && !eos_r);
            out_done_nxt = eos_r && (n_r == LEN_W'(1));
            for (int i = 0; i < ESC_LEN - 1; i++) begin
              buf_nxt[i] = buf_r[i+1];
            end
            n_nxt = n_r - LEN_W'(1);
          end
        end
      end
      ST_ENC: begin
        if (slot_free) begin
          emit_go      = 1'b1;
          out_byte_nxt = enc_byte;
          out_eor_nxt  = (idx_r == len_r - 2'd1);
          out_done_nxt = eos_r && (idx_r == len_r - 2'd1);
          idx_nxt      = idx_r + 2'd1;
          if (idx_r == len_r - 2'd1) begin
            n_nxt = '0;
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          // copy everything held, then pass the rest of the string through
          emit_go      = 1'b1;
          out_byte_nxt = buf_r[0];
          out_eor_nxt  = (n_r == LEN_W'(1));
          out_done_nxt = eos_r && (n_r == LEN_W'(1));
          for (int i = 0; i < ESC_LEN - 1; i++) begin
            buf_nxt[i] = buf_r[i+1];
          end
          n_nxt = n_r - LEN_W'(1);
          if (n_r == LEN_W'(1)) begin
            pass_nxt = 1'b1;
          end
        end
      end
      default: begin
        n_nxt = '0;
      end
    endcase

    // string end drops any held state
    if (state_r != ST_IDLE && state_nxt == ST_IDLE && eos_r) begin
      n_nxt    = '0;
      pass_nxt = 1'b0;
    end

    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= '0;
      pass_r      <= 1'b0;
      skip_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && paddr == ADDR_SKIP_INVALID) begin
        skip_r <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ESC_LEN; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
    eos_r      <= eos_nxt;
    cp_r       <= cp_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_eor_r  <= out_eor_nxt;
    out_done_r <= out_done_nxt;
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_end_of_run  = out_eor_r;
  assign out_string_done = out_done_r;
  assign pready          = 1'b1;
  assign prdata          = (paddr == ADDR_SKIP_INVALID) ?
                           {{(DATA_W-1){1'b0}}, skip_r} : '0;

endmodule
